// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int FILL_W        = 5;

    typedef enum logic [1:0] {
        FN_PUSH_REAR  = 2'd0,
        FN_PUSH_FRONT = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== rtl/deq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: one queue operation per item.
// ----------------------------------------------------------------------------
interface deq_req_if;

    logic                                valid;
    logic                                ready;
    deq_pkg::func_t                      func;
    logic signed [deq_pkg::DATA_W-1:0]   push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);

endinterface

// ===== rtl/deq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: one result item per operation.
// ----------------------------------------------------------------------------
interface deq_rsp_if;

    logic                                valid;
    logic                                ready;
    deq_pkg::status_t                    status;
    logic signed [deq_pkg::DATA_W-1:0]   element_label;
    logic signed [deq_pkg::DATA_W-1:0]   popped_value;
    logic [deq_pkg::FILL_W-1:0]          fill_level;

    modport source (
        output valid, output status, output element_label,
        output popped_value, output fill_level, input ready
    );
    modport sink (
        input valid, input status, input element_label,
        input popped_value, input fill_level, output ready
    );

endinterface

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                          | handshake
//  req     | in  | func, push_value                                | valid/ready
//  rsp     | out | status, element_label, popped_value, fill_level | valid/ready
//
//  Push and error items: result registered in the cycle after acceptance.
//  Successful pops: the memory read data register, then the result register.
//  A new item is taken while no read is pending and the result register is
//  empty or being drained in the same cycle.
//  Asynchronous reset empties the queue at once; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);
    import deq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    mem_ctl_t            mem_ctl;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [DATA_W-1:0]   mem_wr_data;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [DATA_W-1:0]   mem_rd_data;

    deq_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_ctl     (mem_ctl),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    deq_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== rtl/deq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_mem #(
    parameter int DEPTH  = deq_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  deq_pkg::mem_ctl_t           ctl,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [deq_pkg::DATA_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [deq_pkg::DATA_W-1:0]  rd_data
);
    import deq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring pointers, fill count, labels, memory requests and result register.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH  = deq_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    deq_req_if.sink                     req,
    deq_rsp_if.source                   rsp,
    output deq_pkg::mem_ctl_t           mem_ctl,
    output logic [ADDR_W-1:0]           mem_wr_addr,
    output logic [deq_pkg::DATA_W-1:0]  mem_wr_data,
    output logic [ADDR_W-1:0]           mem_rd_addr,
    input  logic [deq_pkg::DATA_W-1:0]  mem_rd_data
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [DATA_W-1:0]   front_label_reg, front_label_next;

    logic                rsp_valid_reg, rsp_valid_next;
    status_t             rsp_status_reg, rsp_status_next;
    logic [DATA_W-1:0]   rsp_label_reg, rsp_label_next;
    logic [DATA_W-1:0]   rsp_value_reg, rsp_value_next;
    logic [FILL_W-1:0]   rsp_fill_reg, rsp_fill_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic                is_push;
    logic [ADDR_W-1:0]   fill_lo;
    logic [ADDR_W-1:0]   rear_off;
    logic [ADDR_W:0]     rear_sum;
    logic [ADDR_W-1:0]   rear_idx;
    logic [ADDR_W-1:0]   head_inc;
    logic [ADDR_W-1:0]   head_dec;
    logic [DATA_W-1:0]   rear_label;

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign is_push  = (req.func == FN_PUSH_REAR) || (req.func == FN_PUSH_FRONT);
    assign fill_lo  = fill_reg[ADDR_W-1:0];
    assign rear_off = is_push ? fill_lo : fill_lo - ADDR_W'(1);
    assign rear_sum = {1'b0, head_reg} + {1'b0, rear_off};
    assign rear_idx = (rear_sum >= (ADDR_W + 1)'(DEPTH))
                    ? ADDR_W'(rear_sum - (ADDR_W + 1)'(DEPTH))
                    : rear_sum[ADDR_W-1:0];
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign rear_label = front_label_reg + DATA_W'(rear_off);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        front_label_next = front_label_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_label_next   = rsp_label_reg;
        rsp_value_next   = rsp_value_reg;
        rsp_fill_next    = rsp_fill_reg;
        mem_ctl          = '0;
        mem_wr_addr      = head_reg;
        mem_wr_data      = req.push_value;
        mem_rd_addr      = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_status_next = ST_DONE;
                    rsp_label_next  = '0;
                    rsp_value_next  = '0;
                    rsp_valid_next  = 1'b1;
                    case (req.func)
                        FN_PUSH_REAR, FN_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                rsp_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                fill_next     = fill_reg + CNT_W'(1);
                                if (empty)
                                begin
                                    front_label_next = '0;
                                end
                                else if (req.func == FN_PUSH_REAR)
                                begin
                                    mem_wr_addr    = rear_idx;
                                    rsp_label_next = rear_label;
                                end
                                else
                                begin
                                    mem_wr_addr      = head_dec;
                                    head_next        = head_dec;
                                    front_label_next = front_label_reg - DATA_W'(1);
                                    rsp_label_next   = front_label_reg - DATA_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                rsp_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                // value arrives from memory next cycle
                                mem_ctl.rd_en  = 1'b1;
                                rsp_valid_next = 1'b0;
                                state_next     = S_READ;
                                fill_next      = fill_reg - CNT_W'(1);
                                if (req.func == FN_POP_FRONT)
                                begin
                                    rsp_label_next   = front_label_reg;
                                    head_next        = head_inc;
                                    front_label_next = front_label_reg + DATA_W'(1);
                                end
                                else
                                begin
                                    mem_rd_addr    = rear_idx;
                                    rsp_label_next = rear_label;
                                end
                            end
                        end
                    endcase
                    rsp_fill_next = FILL_W'(fill_next);
                end
            end
            S_READ:
            begin
                rsp_value_next = mem_rd_data;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            fill_reg        <= '0;
            front_label_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            fill_reg        <= fill_next;
            front_label_reg <= front_label_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_label_reg  <= rsp_label_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_fill_reg   <= rsp_fill_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.element_label = rsp_label_reg;
    assign rsp.popped_value  = rsp_value_reg;
    assign rsp.fill_level    = rsp_fill_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= ADDR_W'(DEPTH - 1))
        else $error("head pointer beyond ring");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_push && !empty |=> state_reg == S_READ)
        else $error("pop did not start a memory read");

    a_read_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !rsp_valid_reg)
        else $error("result register busy during read");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("read data not delivered");

endmodule
